[hw/rtl/rfid_access_lockout_unit_defines.svh]
// Assertion macros for the checker file.
`ifndef RFID_ACCESS_LOCKOUT_UNIT_DEFINES_SVH
`define RFID_ACCESS_LOCKOUT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define RAL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk, idle during reset.
`define RAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

[hw/rtl/ral_pkg.sv]
package ral_pkg;

	// Card table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);

	// Command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_POLL = 2'd1;
	localparam logic [1:0] CMD_LOAD = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_ENABLE        = 3'd0;
	localparam logic [2:0] REG_POLL_INTERVAL = 3'd1;
	localparam logic [2:0] REG_INHIBIT_TIME  = 3'd2;
	localparam logic [2:0] REG_RELEASE_TIME  = 3'd3;
	localparam logic [2:0] REG_MISS_LIMIT    = 3'd4;
	localparam logic [2:0] REG_MISS_DECAY    = 3'd5;

	// Register reset values
	localparam logic [15:0] RST_POLL_INTERVAL = 16'd500;
	localparam logic [15:0] RST_INHIBIT_TIME  = 16'd3000;
	localparam logic [19:0] RST_RELEASE_TIME  = 20'd60000;
	localparam logic [7:0]  RST_MISS_LIMIT    = 8'd10;
	localparam logic [23:0] RST_MISS_DECAY    = 24'd900000;

	localparam logic [7:0] MISS_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  command;
		logic        card_present;
		logic [31:0] card_id;
		logic [3:0]  entry_index;
		logic        entry_valid;
	} in_item_t;

	typedef struct packed {
		logic       poll_accepted;
		logic       open_pulse;
		logic       released;
		logic [3:0] match_index;
		logic [7:0] miss_count;
		logic       locked_out;
	} out_item_t;

	// Table write request
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic [31:0] id;
		logic        valid;
	} tbl_wr_t;

	// Table lookup answer
	typedef struct packed {
		logic                 found;
		logic [TBL_IDX_W-1:0] slot;
	} tbl_hit_t;

endpackage

[hw/rtl/ral_match.sv]
module ral_match (
	input  logic              clk,
	input  logic              arst_n,
	input  ral_pkg::tbl_wr_t  wr,
	input  logic [31:0]       key,
	output ral_pkg::tbl_hit_t hit
);

	logic [31:0]                      id_q    [ral_pkg::TABLE_DEPTH];
	logic [ral_pkg::TABLE_DEPTH-1:0]  valid_q;
	logic [ral_pkg::TABLE_DEPTH-1:0]  eq;
	logic                             wr_ok;
	logic [ral_pkg::TBL_IDX_W-1:0]    wr_idx;

	assign wr_ok  = wr.en && (int'(wr.index) < ral_pkg::TABLE_DEPTH);
	assign wr_idx = ral_pkg::TBL_IDX_W'(wr.index);

	// Valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_ok) begin
			valid_q[wr_idx] <= wr.valid;
		end
	end

	// Card ids, no reset: only read behind a set valid bit
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			id_q[wr_idx] <= wr.id;
		end
	end

	// Parallel compare over all slots
	always_comb begin
		for (int k = 0; k < ral_pkg::TABLE_DEPTH; k++) begin
			eq[k] = valid_q[k] && (id_q[k] == key);
		end
	end

	// Lowest matching slot wins
	always_comb begin
		hit.found = |eq;
		hit.slot  = '0;
		for (int k = ral_pkg::TABLE_DEPTH - 1; k >= 0; k--) begin
			if (eq[k]) begin
				hit.slot = ral_pkg::TBL_IDX_W'(k);
			end
		end
	end

endmodule

[hw/rtl/rfid_access_lockout_unit.sv]
// Channel   Handshake                  Beat
// -------   -------------------------  --------------------------------
// item      start high, busy low       ral_pkg::in_item_t command beat
// result    done high for one cycle    ral_pkg::out_item_t status beat
// config    psel & penable & pwrite    APB register write, 32-bit data
//
// One beat in per cycle; busy stays low. The result passes through the input
// register, then the gate/match/counter logic into the result register.
// State updates land with the result, so the next beat always sees them.
// arst_n clears control state, registers and the table valid bits.
// The result cannot be stalled: done lasts one cycle.
module rfid_access_lockout_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ral_pkg::in_item_t  item,
	output logic               done,
	output ral_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Config registers
	logic        enable_q;
	logic [15:0] poll_interval_q;
	logic [15:0] inhibit_time_q;
	logic [19:0] release_time_q;
	logic [7:0]  miss_limit_q;
	logic [23:0] miss_decay_q;
	logic        cfg_wr;
	logic [2:0]  reg_idx;

	// Input stage
	logic              valid_s1;
	ral_pkg::in_item_t item_s1;

	// Block state
	logic [31:0] now_q;
	logic [31:0] last_poll_q;
	logic [31:0] last_detect_q;
	logic [31:0] rel_start_q;
	logic [31:0] miss_timer_q;
	logic        rel_active_q;
	logic        released_q;
	logic [7:0]  misses_q;

	// Result register
	logic               done_q;
	ral_pkg::out_item_t result_q;

	// Datapath
	ral_pkg::tbl_wr_t  tbl_wr;
	ral_pkg::tbl_hit_t hit;
	logic        is_tick;
	logic        is_poll;
	logic        gate;
	logic        expire;
	logic        detect;
	logic        try_match;
	logic        opened;
	logic        missed;
	logic        decay;
	logic [31:0] d_poll;
	logic [31:0] d_detect;
	logic [31:0] d_release;
	logic [31:0] d_miss;
	logic [7:0]  misses_mid;
	logic [7:0]  misses_nxt;
	logic        released_nxt;
	logic        rel_active_nxt;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign done   = done_q;
	assign result = result_q;

	// APB write decode
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			poll_interval_q <= ral_pkg::RST_POLL_INTERVAL;
			inhibit_time_q  <= ral_pkg::RST_INHIBIT_TIME;
			release_time_q  <= ral_pkg::RST_RELEASE_TIME;
			miss_limit_q    <= ral_pkg::RST_MISS_LIMIT;
			miss_decay_q    <= ral_pkg::RST_MISS_DECAY;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				ral_pkg::REG_ENABLE:        enable_q        <= pwdata[0];
				ral_pkg::REG_POLL_INTERVAL: poll_interval_q <= pwdata[15:0];
				ral_pkg::REG_INHIBIT_TIME:  inhibit_time_q  <= pwdata[15:0];
				ral_pkg::REG_RELEASE_TIME:  release_time_q  <= pwdata[19:0];
				ral_pkg::REG_MISS_LIMIT:    miss_limit_q    <= pwdata[7:0];
				ral_pkg::REG_MISS_DECAY:    miss_decay_q    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// APB read mux
	always_comb begin
		unique case (reg_idx)
			ral_pkg::REG_ENABLE:        prdata = {31'b0, enable_q};
			ral_pkg::REG_POLL_INTERVAL: prdata = {16'b0, poll_interval_q};
			ral_pkg::REG_INHIBIT_TIME:  prdata = {16'b0, inhibit_time_q};
			ral_pkg::REG_RELEASE_TIME:  prdata = {12'b0, release_time_q};
			ral_pkg::REG_MISS_LIMIT:    prdata = {24'b0, miss_limit_q};
			ral_pkg::REG_MISS_DECAY:    prdata = {8'b0, miss_decay_q};
			default:                    prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Card table
	assign tbl_wr.en    = valid_s1 && (item_s1.command == ral_pkg::CMD_LOAD);
	assign tbl_wr.index = item_s1.entry_index;
	assign tbl_wr.id    = item_s1.card_id;
	assign tbl_wr.valid = item_s1.entry_valid;

	ral_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.key    (item_s1.card_id),
		.hit    (hit)
	);

	// Poll gate and elapsed times, all modulo 2^32
	assign is_tick   = valid_s1 && (item_s1.command == ral_pkg::CMD_TICK);
	assign is_poll   = valid_s1 && (item_s1.command == ral_pkg::CMD_POLL);
	assign d_poll    = now_q - last_poll_q;
	assign d_detect  = now_q - last_detect_q;
	assign d_release = now_q - rel_start_q;
	assign d_miss    = now_q - miss_timer_q;

	assign gate = is_poll && enable_q
		&& !(d_poll < {16'b0, poll_interval_q})
		&& !(d_detect < {16'b0, inhibit_time_q});
	assign expire    = rel_active_q && (d_release > {12'b0, release_time_q});
	assign detect    = gate && item_s1.card_present;
	assign try_match = detect && (misses_q < miss_limit_q);
	assign opened    = try_match && hit.found;
	assign missed    = try_match && !hit.found;

	// Miss counter: clear on hit, saturating count on miss, then decay
	always_comb begin
		if (opened) begin
			misses_mid = '0;
		end else if (missed && (misses_q != ral_pkg::MISS_MAX)) begin
			misses_mid = misses_q + 8'd1;
		end else begin
			misses_mid = misses_q;
		end
	end

	// A fresh miss resets the timer to now, so it cannot decay this beat
	assign decay = gate && !missed && (misses_mid != 8'd0)
		&& (d_miss > {8'b0, miss_decay_q});
	assign misses_nxt = decay ? (misses_mid - 8'd1) : misses_mid;

	// Release state
	always_comb begin
		priority if (opened) begin
			released_nxt   = 1'b1;
			rel_active_nxt = 1'b1;
		end else if (gate && expire) begin
			released_nxt   = 1'b0;
			rel_active_nxt = 1'b0;
		end else begin
			released_nxt   = released_q;
			rel_active_nxt = rel_active_q;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_poll_q   <= '0;
			last_detect_q <= '0;
			rel_start_q   <= '0;
			miss_timer_q  <= '0;
			rel_active_q  <= 1'b0;
			released_q    <= 1'b0;
			misses_q      <= '0;
		end else begin
			if (is_tick) begin
				now_q <= now_q + 32'd1;
			end
			if (gate) begin
				last_poll_q <= now_q;
			end
			if (detect) begin
				last_detect_q <= now_q;
			end
			if (opened) begin
				rel_start_q <= now_q;
			end
			if (missed || decay) begin
				miss_timer_q <= now_q;
			end
			rel_active_q <= rel_active_nxt;
			released_q   <= released_nxt;
			misses_q     <= misses_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.poll_accepted <= gate;
			result_q.open_pulse    <= opened;
			result_q.released      <= released_nxt;
			result_q.match_index   <= opened ? 4'(hit.slot) : 4'd0;
			result_q.miss_count    <= misses_nxt;
			result_q.locked_out    <= misses_nxt >= miss_limit_q;
		end
	end

endmodule

[hw/rtl/ral_checker.sv]
`include "rfid_access_lockout_unit_defines.svh"

module ral_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input ral_pkg::out_item_t result
);

	// Every accepted beat yields exactly one result
	`RAL_ASSERT_NEXT(a_one_result, start && !busy, ##1 done)
	`RAL_ASSERT_NEXT(a_no_spurious, !(start && !busy), ##1 !done)

	// An open comes from an accepted poll, grants release and clears misses
	`RAL_ASSERT_NOW(a_open_state, done && result.open_pulse,
		result.poll_accepted && result.released && (result.miss_count == 8'd0)
		&& !result.locked_out)

	// Slot index is only reported with an open
	`RAL_ASSERT_NOW(a_idx_zero, done && !result.open_pulse, result.match_index == 4'd0)

endmodule

bind rfid_access_lockout_unit ral_checker u_ral_checker (.*);
